// ----- hdl/assert_macros.svh -----
// assertion helpers shared by the resampler modules
// each macro expects clk_i and rst_ni in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SLR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slr assertion failed");

// next-cycle implication
`define SLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slr assertion failed");

`endif

// ----- hdl/slr_pkg.sv -----
`default_nettype none

package slr_pkg;

  // field and register widths
  localparam int SAMPLE_W     = 16;
  localparam int STEP_W       = 20;
  localparam int VOL_W        = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 20;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_RESULTS  = 8;

  // register reset values
  localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;
  localparam logic [VOL_W-1:0]  VOL_RESET  = 4'd15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME     = 1'b1;

  // beat function codes
  localparam logic FUNC_FRAME   = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  // divide by fifteen: q = (m * DIV15_MUL) >> DIV15_SHIFT, exact for m < 2^20
  localparam int DIV15_MAG_W            = 19;
  localparam logic [19:0] DIV15_MUL     = 20'd559241;
  localparam int DIV15_SHIFT            = 23;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] src_left;
    logic signed [SAMPLE_W-1:0] src_right;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       last_of_run;
  } out_beat_t;

endpackage

`default_nettype wire

// ----- hdl/slr_lane.sv -----
`default_nettype none

// one channel: interpolate, scale by volume/15, saturate; three register stages
module slr_lane #(
  parameter int FracBits = slr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0]  start_i,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0]  end_i,
  input  wire logic        [FracBits-1:0]           frac_i,
  input  wire logic        [slr_pkg::VOL_W-1:0]     vol_i,
  output logic signed      [slr_pkg::SAMPLE_W-1:0]  sample_o
);

  localparam int SW      = slr_pkg::SAMPLE_W;
  localparam int DIFF_W  = SW + 1;
  localparam int PROD_W  = DIFF_W + FracBits + 1;
  localparam int VM_W    = DIFF_W + slr_pkg::VOL_W + 1;
  localparam int MAG_W   = slr_pkg::DIV15_MAG_W;
  localparam int REC_W   = MAG_W + 20;
  localparam int Q_W     = REC_W - slr_pkg::DIV15_SHIFT;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [FracBits:0]   frac_s;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [SW-1:0]       start_q;
  logic signed [PROD_W-1:0]   shifted;
  logic signed [DIFF_W-1:0]   interp;
  logic signed [slr_pkg::VOL_W:0] vol_s;
  logic signed [VM_W-1:0]     vm_d, vm_q;
  logic        [VM_W-1:0]     vm_abs;
  logic        [REC_W-1:0]    rec_d, rec_q;
  logic                       neg_q;
  logic        [Q_W-1:0]      quot;
  logic signed [Q_W:0]        signed_q;

  // stage 1: slope times fraction
  assign diff   = DIFF_W'(end_i) - DIFF_W'(start_i);
  assign frac_s = $signed({1'b0, frac_i});
  assign prod_d = PROD_W'(diff) * PROD_W'(frac_s);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      start_q <= start_i;
    end
  end

  // stage 2: floor shift, add base, apply gain
  assign shifted = prod_q >>> FracBits;
  assign interp  = DIFF_W'(start_q) + $signed(shifted[DIFF_W-1:0]);
  assign vol_s   = $signed({1'b0, vol_i});
  assign vm_d    = VM_W'(interp) * VM_W'(vol_s);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vm_q <= vm_d;
    end
  end

  // stage 3: magnitude times reciprocal of fifteen
  assign vm_abs = vm_q[VM_W-1] ? VM_W'(-vm_q) : VM_W'(vm_q);
  assign rec_d  = REC_W'(vm_abs[MAG_W-1:0]) * REC_W'(slr_pkg::DIV15_MUL);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rec_q <= rec_d;
      neg_q <= vm_q[VM_W-1];
    end
  end

  // restore sign (truncation toward zero) and saturate
  assign quot     = rec_q[REC_W-1:slr_pkg::DIV15_SHIFT];
  assign signed_q = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  always_comb begin
    if (signed_q > (Q_W+1)'(32767)) begin
      sample_o = 16'sh7fff;
    end else if (signed_q < -(Q_W+1)'(32768)) begin
      sample_o = 16'sh8000;
    end else begin
      sample_o = signed_q[SW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/slr_merge.sv -----
`default_nettype none

`include "assert_macros.svh"

// joins both lanes into one output beat and holds it under stall
module slr_merge (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  input  wire logic                                last_i,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0] left_i,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0] right_i,
  output logic                                     adv_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output slr_pkg::out_beat_t                       out_beat_o
);

  logic               out_valid_q;
  slr_pkg::out_beat_t out_beat_q;

  // pipeline moves whenever the output slot is free or being taken
  assign adv_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && valid_i) begin
      out_beat_q.out_left    <= left_i;
      out_beat_q.out_right   <= right_i;
      out_beat_q.last_of_run <= last_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // a beat arriving while blocked must never be dropped
  `SLR_ASSERT_NEXT(a_hold_arrival, valid_i && !adv_o, out_valid_q)

endmodule

`default_nettype wire

// ----- hdl/stereo_linear_resampler_core.sv -----
// stereo linear resampler
// input channel: in_valid_i / in_stall_o carry one in_beat_t; func selects a
// source frame or a restart that clears the previous frame and the phase.
// output channel: out_valid_o / out_stall_i carry interpolated stereo frames;
// last_of_run marks the final output frame caused by one source frame.
// config: cfg_we_i writes phase_step (index 0) or volume (index 1); the user
// must write them only while idle, which the block itself does not enforce.
// a source frame producing n outputs (n at most 8) is accepted, then one
// output is issued per cycle while the pipeline advances; no new beat is
// taken until its last output has issued. a restart, a first frame or a frame
// with no output issues nothing. each output passes the three-stage lane
// datapath (slope multiply, gain, divide by 15) and then the output register.
// the two channels run in parallel lanes; the output register merges them.
// when the receiver stalls, the whole lane pipeline freezes and issuing halts;
// a new source frame can still be accepted while results wait.
// reset: phase_step = 1.0, volume = 15, no previous frame, phase zero,
// output empty.
`default_nettype none

`include "assert_macros.svh"

module stereo_linear_resampler_core #(
  parameter int FracBits = slr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire slr_pkg::in_beat_t                  in_beat_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output slr_pkg::out_beat_t                      out_beat_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [slr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [slr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int SW      = slr_pkg::SAMPLE_W;
  localparam int STEP_W  = slr_pkg::STEP_W;
  localparam int PHASE_W = ((FracBits > STEP_W) ? FracBits : STEP_W) + 1;
  localparam int CNT_W   = $clog2(slr_pkg::MAX_RESULTS);
  localparam logic [PHASE_W-1:0] ONE = PHASE_W'(1) << FracBits;
  localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(slr_pkg::MAX_RESULTS - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_e;

  state_e                  state_q, state_d;
  logic [STEP_W-1:0]       step_q;
  logic [slr_pkg::VOL_W-1:0] vol_q;
  logic signed [SW-1:0]    prev_l_q, prev_r_q, cur_l_q, cur_r_q;
  logic                    have_prev_q;
  logic [PHASE_W-1:0]      phase_q, phase_next, phase_retire;
  logic [CNT_W-1:0]        cnt_q;
  logic                    in_acc, adv, issue, issue_last;
  logic [2:0]              pv_q, pl_q;
  logic signed [SW-1:0]    lane_l, lane_r;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= slr_pkg::STEP_RESET;
      vol_q  <= slr_pkg::VOL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        slr_pkg::REG_PHASE_STEP: step_q <= cfg_data_i[STEP_W-1:0];
        slr_pkg::REG_VOLUME:     vol_q  <= cfg_data_i[slr_pkg::VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and issue control
  assign in_stall_o   = (state_q != S_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign issue        = (state_q == S_EMIT) && adv;
  assign phase_next   = phase_q + PHASE_W'(step_q);
  assign issue_last   = (phase_next >= ONE) || (cnt_q == CNT_LAST);
  assign phase_retire = (phase_next >= ONE) ? (phase_next - ONE) : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_beat_i.func == slr_pkg::FUNC_FRAME) && have_prev_q &&
            (phase_q < ONE)) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (issue && issue_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer state: phase cursor, previous frame, output count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      have_prev_q <= 1'b0;
      phase_q     <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (in_beat_i.func == slr_pkg::FUNC_RESTART) begin
          have_prev_q <= 1'b0;
          phase_q     <= '0;
          prev_l_q    <= '0;
          prev_r_q    <= '0;
        end else if (!have_prev_q) begin
          have_prev_q <= 1'b1;
          prev_l_q    <= in_beat_i.src_left;
          prev_r_q    <= in_beat_i.src_right;
        end else if (phase_q >= ONE) begin
          // frame already passed: retire it without output
          phase_q  <= phase_q - ONE;
          prev_l_q <= in_beat_i.src_left;
          prev_r_q <= in_beat_i.src_right;
        end else begin
          cnt_q <= '0;
        end
      end else if (issue) begin
        if (issue_last) begin
          phase_q  <= phase_retire;
          prev_l_q <= cur_l_q;
          prev_r_q <= cur_r_q;
        end else begin
          phase_q <= phase_next;
          cnt_q   <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  // new frame held during its run
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_l_q <= in_beat_i.src_left;
      cur_r_q <= in_beat_i.src_right;
    end
  end

  // lane pipeline valid and last flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
      pl_q <= '0;
    end else if (adv) begin
      pv_q <= {pv_q[1:0], issue};
      pl_q <= {pl_q[1:0], issue && issue_last};
    end
  end

  // left and right lanes
  slr_lane #(
    .FracBits (FracBits)
  ) u_lane_left (
    .clk_i    (clk_i),
    .en_i     (adv),
    .start_i  (prev_l_q),
    .end_i    (cur_l_q),
    .frac_i   (phase_q[FracBits-1:0]),
    .vol_i    (vol_q),
    .sample_o (lane_l)
  );

  slr_lane #(
    .FracBits (FracBits)
  ) u_lane_right (
    .clk_i    (clk_i),
    .en_i     (adv),
    .start_i  (prev_r_q),
    .end_i    (cur_r_q),
    .frac_i   (phase_q[FracBits-1:0]),
    .vol_i    (vol_q),
    .sample_o (lane_r)
  );

  // merge lanes into the output register
  slr_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (pv_q[2]),
    .last_i      (pl_q[2]),
    .left_i      (lane_l),
    .right_i     (lane_r),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  // the cursor is inside the current interval while outputs are issued
  `SLR_ASSERT_IMPL(a_phase_in_range, state_q == S_EMIT, phase_q < ONE)
  // the final issue of a run returns the sequencer to idle
  `SLR_ASSERT_NEXT(a_last_ends_run, issue && issue_last, state_q == S_IDLE)
  // a frozen pipeline keeps its beats in place
  `SLR_ASSERT_NEXT(a_pipe_frozen, !adv, $stable(pv_q) && $stable(pl_q))

endmodule

`default_nettype wire

// ----- dv/stereo_linear_resampler_core_tb.sv -----
`timescale 1ns / 1ps

module stereo_linear_resampler_core_tb;

  localparam int     STEP_BITS   = slr_pkg::STEP_W;
  localparam int     VOL_BITS    = slr_pkg::VOL_W;
  localparam int     SMP_BITS    = slr_pkg::SAMPLE_W;
  localparam longint ONE_PHASE   = longint'(1) << slr_pkg::FRAC_BITS_DEF;
  localparam longint GAIN_DIV    = 15;
  localparam longint SAMPLE_MAX  = 32767;
  localparam longint SAMPLE_MIN  = -32768;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SEG_ITEMS       = 10;
  localparam int RESET_CYCLES    = 8;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} check_e;
  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    slr_pkg::in_beat_t    beat;
    check_e               chk;
    slr_pkg::out_beat_t   one;
    logic [STEP_BITS-1:0] step;
    logic [VOL_BITS-1:0]  vol;
  } stim_row_t;

  typedef struct packed {
    check_e             chk;
    slr_pkg::out_beat_t one;
  } beat_note_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  slr_pkg::in_beat_t              in_beat_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  slr_pkg::out_beat_t             out_beat_o;
  logic                           cfg_we_i;
  logic [slr_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [slr_pkg::CFG_DATA_W-1:0] cfg_data_i;

  // resampler state as the testbench sees it
  logic [STEP_BITS-1:0] rate_step;
  logic [VOL_BITS-1:0]  gain;
  longint               held_left;
  longint               held_right;
  longint               cursor;
  bit                   holding_frame;
  slr_pkg::out_beat_t   run_buf [slr_pkg::MAX_RESULTS];

  slr_pkg::out_beat_t frames_due[$];
  beat_note_t         beat_notes[$];
  stim_row_t          directed_rows[$];

  int err_cnt = 0;
  int cycle_cnt = 0;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;

  stereo_linear_resampler_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // interpolate at the cursor fraction, apply gain, clamp
  function automatic logic [SMP_BITS-1:0] lerp_scale(longint a, longint b,
                                                     longint frac);
    longint v;
    v = a + (((b - a) * frac) >>> slr_pkg::FRAC_BITS_DEF);
    v = (v * longint'(gain)) / GAIN_DIV;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    else if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    return v[SMP_BITS-1:0];
  endfunction

  // advance the resampler by one input beat, output frames go to run_buf
  function automatic int resample_frame(slr_pkg::in_beat_t b);
    longint nl;
    longint nr;
    int n;
    n = 0;
    if (b.func == slr_pkg::FUNC_RESTART) begin
      held_left = 0;
      held_right = 0;
      holding_frame = 1'b0;
      cursor = 0;
      return 0;
    end
    nl = longint'($signed(b.src_left));
    nr = longint'($signed(b.src_right));
    if (!holding_frame) begin
      held_left = nl;
      held_right = nr;
      holding_frame = 1'b1;
      return 0;
    end
    while (cursor < ONE_PHASE && n < slr_pkg::MAX_RESULTS) begin
      run_buf[n].out_left = lerp_scale(held_left, nl, cursor);
      run_buf[n].out_right = lerp_scale(held_right, nr, cursor);
      run_buf[n].last_of_run = 1'b0;
      cursor = cursor + longint'(rate_step);
      n++;
    end
    if (n > 0) run_buf[n-1].last_of_run = 1'b1;
    // retire one source frame, no wrap below zero
    cursor = (cursor >= ONE_PHASE) ? cursor - ONE_PHASE : 0;
    held_left = nl;
    held_right = nr;
    return n;
  endfunction

  function automatic stim_row_t beat_row(logic func, logic [15:0] l, logic [15:0] r,
                                         check_e chk, logic [15:0] el, logic [15:0] er);
    stim_row_t row;
    row = '0;
    row.kind = ROW_BEAT;
    row.beat.func = func;
    row.beat.src_left = l;
    row.beat.src_right = r;
    row.chk = chk;
    row.one.out_left = el;
    row.one.out_right = er;
    row.one.last_of_run = 1'b1;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [STEP_BITS-1:0] step,
                                        logic [VOL_BITS-1:0] vol);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.step = step;
    row.vol = vol;
    return row;
  endfunction

  function automatic logic [SMP_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return SMP_BITS'($urandom);
    endcase
  endfunction

  // offer one input beat, with random idle cycles ahead of it
  task automatic send_beat(slr_pkg::in_beat_t b, check_e chk, slr_pkg::out_beat_t one);
    beat_note_t note;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    note.chk = chk;
    note.one = one;
    beat_notes.push_back(note);
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // wait until every expected frame is out and the pipeline has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(logic [STEP_BITS-1:0] step, logic [VOL_BITS-1:0] vol);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= slr_pkg::REG_PHASE_STEP;
    cfg_data_i <= step;
    @(posedge clk_i);
    cfg_idx_i <= slr_pkg::REG_VOLUME;
    cfg_data_i <= {{(slr_pkg::CFG_DATA_W-VOL_BITS){1'b0}}, vol};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rate_step = step;
    gain = vol;
  endtask

  // receiver: random stall, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // score output beats, then predict from accepted input beats
  always @(posedge clk_i) begin : score
    slr_pkg::out_beat_t want;
    beat_note_t         note;
    int                 n;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frames_due.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected beat, expected none, got L=%0d R=%0d last=%0b", $time,
                 out_beat_o.out_left, out_beat_o.out_right, out_beat_o.last_of_run);
      end else begin
        want = frames_due.pop_front();
        if (out_beat_o.out_left !== want.out_left) begin
          err_cnt++;
          $display("%0t: out_left expected %0d got %0d", $time,
                   want.out_left, out_beat_o.out_left);
        end
        if (out_beat_o.out_right !== want.out_right) begin
          err_cnt++;
          $display("%0t: out_right expected %0d got %0d", $time,
                   want.out_right, out_beat_o.out_right);
        end
        if (out_beat_o.last_of_run !== want.last_of_run) begin
          err_cnt++;
          $display("%0t: last_of_run expected %0b got %0b", $time,
                   want.last_of_run, out_beat_o.last_of_run);
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      note = beat_notes.pop_front();
      n = resample_frame(in_beat_i);
      if (note.chk == CHK_ONE) begin
        frames_due.push_back(note.one);
      end else if (note.chk == CHK_MODEL) begin
        for (int i = 0; i < n; i++) frames_due.push_back(run_buf[i]);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t            row;
    slr_pkg::in_beat_t    b;
    logic [STEP_BITS-1:0] step;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_beat_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    rate_step = slr_pkg::STEP_RESET;
    gain = slr_pkg::VOL_RESET;
    held_left = 0;
    held_right = 0;
    cursor = 0;
    holding_frame = 1'b0;
    hold_req = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 88;

    // directed table: reset settings, extremes, restart, first frame, small
    // step, step past one, gain zero
    directed_rows.push_back(beat_row(slr_pkg::FUNC_RESTART, 16'hFFFF, 16'hFFFF, CHK_NONE,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h0000, 16'h0000, CHK_NONE,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h7FFF, 16'h8000, CHK_ONE,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h8000, 16'h7FFF, CHK_ONE,
                                     16'h7FFF, 16'h8000));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'hFFFF, 16'h0000, CHK_ONE,
                                     16'h8000, 16'h7FFF));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_RESTART, 16'h1234, 16'hABCD, CHK_NONE,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h7FFF, 16'h7FFF, CHK_NONE,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h0000, 16'h0000, CHK_ONE,
                                     16'h7FFF, 16'h7FFF));
    directed_rows.push_back(cfg_row(20'd65536, 4'd0));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h3039, 16'hCFC7, CHK_ONE,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h8000, 16'h7FFF, CHK_ONE,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(cfg_row(20'd16384, 4'd15));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h7FFF, 16'h8000, CHK_MODEL,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h8000, 16'h7FFF, CHK_MODEL,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(cfg_row(20'd1, 4'd9));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h0064, 16'hFF9C, CHK_MODEL,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h8000, 16'h7FFF, CHK_MODEL,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(cfg_row(20'hFFFFF, 4'd15));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h0001, 16'h0002, CHK_MODEL,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h0003, 16'h0004, CHK_MODEL,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_RESTART, 16'h0000, 16'h0000, CHK_NONE,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(cfg_row(20'd524288, 4'd7));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h7FFF, 16'h8000, CHK_NONE,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h8000, 16'h7FFF, CHK_MODEL,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h03E8, 16'hFC18, CHK_MODEL,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(cfg_row(20'd8192, 4'd13));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h8000, 16'h7FFF, CHK_MODEL,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h7FFF, 16'h8000, CHK_MODEL,
                                     16'h0000, 16'h0000));
    directed_rows.push_back(beat_row(slr_pkg::FUNC_FRAME, 16'h5555, 16'hAAAA, CHK_MODEL,
                                     16'h0000, 16'h0000));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) set_config(row.step, row.vol);
      else send_beat(row.beat, row.chk, row.one);
    end

    // random stream under three idling regimes, a fresh setting per segment
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 88 : 0;
      recv_idle_pct = (mode == 0) ? 88 : (mode == 1) ? 34 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        case ($urandom_range(9))
          0: step = STEP_BITS'($urandom_range(8191));
          1: step = STEP_BITS'($urandom_range(20'hFFFFF, 524289));
          2: step = 20'd8192;
          3: step = 20'd524288;
          default: step = STEP_BITS'($urandom_range(524288, 8192));
        endcase
        set_config(step, VOL_BITS'($urandom_range(15)));
        // long receiver hold-off while the sender keeps offering
        if (mode == 2 && seg == 0) hold_req = 1'b1;
        for (int k = 0; k < SEG_ITEMS; k++) begin
          b.func = ($urandom_range(99) < 6) ? slr_pkg::FUNC_RESTART : slr_pkg::FUNC_FRAME;
          b.src_left = pick_sample();
          b.src_right = pick_sample();
          send_beat(b, CHK_MODEL, '0);
        end
      end
    end

    drain();
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- stereo_linear_resampler_core.f -----
+incdir+hdl
hdl/slr_pkg.sv
hdl/slr_lane.sv
hdl/slr_merge.sv
hdl/stereo_linear_resampler_core.sv
dv/stereo_linear_resampler_core_tb.sv
